@@ hdl/vd3_pkg.sv @@
package vd3_pkg;

    // Default width of one signed point component.
    localparam int COMPONENT_BITS_DEF = 16;

endpackage

@@ hdl/vector_distance_3d.sv @@
// Channel   Direction  Ports                                   Beat contents
// --------  ---------  --------------------------------------  ----------------------------
// s_        in         s_valid, s_ready, s_a_*, s_b_*          two signed 3D points A and B
// m_        out        m_valid, m_ready, m_distance            floor(|A - B|), unsigned
//
// One beat enters per cycle and a result leaves per cycle once the pipeline has filled,
// unless m_ready stalls the output. There is one stage each for the differences, the
// squares and the sum, then one stage per bit of the square root.
// Reset (aresetn, synchronous, active low) clears only the valid bits of the stages.
// A stalled output holds its beat; stages behind it keep moving and close up any
// bubbles, so input is still taken until every stage holds a beat.

module vector_distance_3d
    import vd3_pkg::*;
#(
    parameter int COMPONENT_BITS = COMPONENT_BITS_DEF
) (
    input  logic                        aclk,
    input  logic                        aresetn,

    input  logic                        s_valid,
    output logic                        s_ready,
    input  logic signed [COMPONENT_BITS-1:0] s_a_x,
    input  logic signed [COMPONENT_BITS-1:0] s_a_y,
    input  logic signed [COMPONENT_BITS-1:0] s_a_z,
    input  logic signed [COMPONENT_BITS-1:0] s_b_x,
    input  logic signed [COMPONENT_BITS-1:0] s_b_y,
    input  logic signed [COMPONENT_BITS-1:0] s_b_z,

    output logic                        m_valid,
    input  logic                        m_ready,
    output logic [COMPONENT_BITS:0]     m_distance
);

    // Widths derived from the component width.
    localparam int N   = COMPONENT_BITS;
    localparam int DW  = N + 1;        // signed difference
    localparam int R   = N + 1;        // root bits, one pipeline stage each
    localparam int SW  = 2 * R;        // exact sum of three squares
    localparam int RW  = R + 3;        // remainder after the two-bit shift
    localparam int NST = R + 3;        // total stages

    // Stage indexes of the front end.
    localparam int ST_DIFF = 0;
    localparam int ST_SQ   = 1;
    localparam int ST_SUM  = 2;
    localparam int ST_ROOT = 3;

    // Per-stage valid bits and load enables. A stage loads when it is empty or
    // when the stage after it is loading, so bubbles are squeezed out on a stall.
    logic [NST-1:0] vld_reg;
    logic [NST-1:0] vld_next;
    logic [NST-1:0] ld;

    always_comb begin
        ld[NST-1] = !vld_reg[NST-1] || m_ready;
        for (int i = NST - 2; i >= 0; i--) begin
            ld[i] = !vld_reg[i] || ld[i+1];
        end
    end

    always_comb begin
        vld_next = vld_reg;
        for (int i = 0; i < NST; i++) begin
            if (ld[i]) begin
                vld_next[i] = (i == 0) ? s_valid : vld_reg[(i == 0) ? 0 : i - 1];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else begin
            vld_reg <= vld_next;
        end
    end

    assign s_ready = ld[ST_DIFF];

    // Stage: absolute differences. The magnitude of an N+1 bit difference of two
    // N bit values never exceeds 2^N - 1, so it fits in N bits.
    logic [N-1:0] mag_reg  [3];
    logic [N-1:0] mag_next [3];

    always_comb begin
        logic signed [DW-1:0] d [3];
        logic signed [DW-1:0] neg [3];
        d[0] = {s_a_x[N-1], s_a_x} - {s_b_x[N-1], s_b_x};
        d[1] = {s_a_y[N-1], s_a_y} - {s_b_y[N-1], s_b_y};
        d[2] = {s_a_z[N-1], s_a_z} - {s_b_z[N-1], s_b_z};
        for (int c = 0; c < 3; c++) begin
            neg[c]      = -d[c];
            mag_next[c] = d[c][DW-1] ? neg[c][N-1:0] : d[c][N-1:0];
        end
    end

    // Stage: squares, one multiplier per axis.
    logic [2*N-1:0] sq_reg [3];

    // Stage: exact sum of the three squares.
    logic [SW-1:0] sum_reg;
    logic [SW-1:0] sum_next;

    assign sum_next = SW'(sq_reg[0]) + SW'(sq_reg[1]) + SW'(sq_reg[2]);

    always_ff @(posedge aclk) begin
        if (ld[ST_DIFF]) begin
            mag_reg <= mag_next;
        end
        if (ld[ST_SQ]) begin
            for (int c = 0; c < 3; c++) begin
                sq_reg[c] <= mag_reg[c] * mag_reg[c];
            end
        end
        if (ld[ST_SUM]) begin
            sum_reg <= sum_next;
        end
    end

    // Square root, one result bit per stage, most significant first. Each stage
    // brings down the next two radicand bits and tries to subtract 4*root + 1.
    logic [RW-1:0] rem_reg   [R];
    logic [RW-1:0] rem_next  [R];
    logic [R-1:0]  root_reg  [R];
    logic [R-1:0]  root_next [R];
    logic [SW-1:0] rad_reg   [R];
    logic [SW-1:0] rad_next  [R];

    always_comb begin
        logic [RW-1:0] rem_in;
        logic [R-1:0]  root_in;
        logic [SW-1:0] rad_in;
        logic [RW-1:0] rem_sh;
        logic [RW-1:0] trial;
        for (int k = 0; k < R; k++) begin
            if (k == 0) begin
                rem_in  = '0;
                root_in = '0;
                rad_in  = sum_reg;
            end else begin
                rem_in  = rem_reg[(k == 0) ? 0 : k - 1];
                root_in = root_reg[(k == 0) ? 0 : k - 1];
                rad_in  = rad_reg[(k == 0) ? 0 : k - 1];
            end
            rem_sh      = {rem_in[RW-3:0], rad_in[SW-1:SW-2]};
            trial       = {1'b0, root_in, 2'b01};
            rad_next[k] = {rad_in[SW-3:0], 2'b00};
            if (rem_sh >= trial) begin
                rem_next[k]  = rem_sh - trial;
                root_next[k] = {root_in[R-2:0], 1'b1};
            end else begin
                rem_next[k]  = rem_sh;
                root_next[k] = {root_in[R-2:0], 1'b0};
            end
        end
    end

    always_ff @(posedge aclk) begin
        for (int k = 0; k < R; k++) begin
            if (ld[ST_ROOT + k]) begin
                rem_reg[k]  <= rem_next[k];
                root_reg[k] <= root_next[k];
                rad_reg[k]  <= rad_next[k];
            end
        end
    end

    // The last root stage is the output register.
    assign m_valid    = vld_reg[NST-1];
    assign m_distance = root_reg[R-1];

endmodule

@@ hdl/vd3_checker.sv @@
module vd3_checker
    import vd3_pkg::*;
#(
    parameter int COMPONENT_BITS = COMPONENT_BITS_DEF
) (
    input logic                          aclk,
    input logic                          aresetn,
    input logic                          m_valid,
    input logic                          m_ready,
    input logic [COMPONENT_BITS:0]       m_distance
);

    // A result waiting on the output stays offered.
    a_hold_valid: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid)
        else $error("result beat dropped while stalled");

    // A result waiting on the output keeps its value.
    a_hold_data: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> $stable(m_distance))
        else $error("result beat changed while stalled");

    // Reset empties the pipeline.
    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result offered right after reset");

    // The pipeline is deeper than two stages, so a beat taken right after reset cannot
    // reach the output by the time this property checks.
    a_reset_latency: assert property (@(posedge aclk)
        !aresetn ##1 1'b1 |=> !m_valid)
        else $error("result appeared sooner than the pipeline depth allows");

endmodule

bind vector_distance_3d vd3_checker #(
    .COMPONENT_BITS(COMPONENT_BITS)
) u_vd3_checker (.*);
